>>> design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that stays checked through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/pfc_pkg.sv
// Types, constants and helpers for the playfield pixel compositor.
package pfc_pkg;

    localparam int PatternBits  = 4 + 8 + 8;
    localparam int HalfColumns  = PatternBits * 4;
    localparam int CollBits     = 15;
    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits  = 8;
    localparam int CellBits     = 6;
    localparam int PatIdxBits   = $clog2(PatternBits);

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_PATTERN_FIRST = 3'd0,
        CFG_PATTERN_MID   = 3'd1,
        CFG_PATTERN_LAST  = 3'd2,
        CFG_FIELD_CTRL    = 3'd3,
        CFG_P0_COLOUR     = 3'd4,
        CFG_P1_COLOUR     = 3'd5,
        CFG_FIELD_COLOUR  = 3'd6,
        CFG_BACK_COLOUR   = 3'd7
    } t_cfg_index;

    typedef enum logic [2:0] {
        SRC_P0   = 3'd0,
        SRC_P1   = 3'd1,
        SRC_BALL = 3'd2,
        SRC_M0   = 3'd3,
        SRC_M1   = 3'd4,
        SRC_PF   = 3'd5,
        SRC_BG   = 3'd6
    } t_source;

    typedef struct packed {
        logic [7:0] column;
        logic       has_player0;
        logic       has_player1;
        logic       has_missile0;
        logic       has_missile1;
        logic       has_ball;
    } t_in_item;

    typedef struct packed {
        logic [3:0]          hue;
        logic [2:0]          luminance;
        logic [2:0]          source;
        logic                field_bit;
        logic [CollBits-1:0] collision_flags;
    } t_out_item;

    typedef struct packed {
        logic [3:0] pattern_first_nibble;
        logic [7:0] pattern_middle_byte;
        logic [7:0] pattern_last_byte;
        logic       reflect;
        logic       score_mode;
        logic [7:0] player0_colour;
        logic [7:0] player1_colour;
        logic [7:0] field_colour;
        logic [7:0] backdrop_colour;
    } t_cfg;

    // Pattern in drawing order: bit k is the k-th cell from the left edge.
    function automatic logic [PatternBits-1:0] draw_order(input t_cfg cfg);
        logic [PatternBits-1:0] pat;
        for (int i = 0; i < 4; i++) begin
            pat[i] = cfg.pattern_first_nibble[i];
        end
        for (int i = 0; i < 8; i++) begin
            pat[4 + i]  = cfg.pattern_middle_byte[7 - i];
            pat[12 + i] = cfg.pattern_last_byte[i];
        end
        return pat;
    endfunction

endpackage

>>> design/pfc_cfg_regs.sv
// Configuration register file of the playfield pixel compositor.
module pfc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pfc_pkg::CfgIndexBits-1:0]  i_cfg_index,
    input  logic [pfc_pkg::CfgDataBits-1:0]   i_cfg_data,
    output pfc_pkg::t_cfg                     o_cfg
);
    import pfc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_FIRST: r_cfg.pattern_first_nibble <= i_cfg_data[3:0];
                CFG_PATTERN_MID:   r_cfg.pattern_middle_byte  <= i_cfg_data;
                CFG_PATTERN_LAST:  r_cfg.pattern_last_byte    <= i_cfg_data;
                CFG_FIELD_CTRL: begin
                    r_cfg.reflect    <= i_cfg_data[0];
                    r_cfg.score_mode <= i_cfg_data[1];
                end
                CFG_P0_COLOUR:     r_cfg.player0_colour  <= i_cfg_data;
                CFG_P1_COLOUR:     r_cfg.player1_colour  <= i_cfg_data;
                CFG_FIELD_COLOUR:  r_cfg.field_colour    <= i_cfg_data;
                CFG_BACK_COLOUR:   r_cfg.backdrop_colour <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/pfc_compose.sv
// Pixel logic: playfield lookup, collision hits, priority and colour pick.
module pfc_compose (
    input  pfc_pkg::t_cfg                  i_cfg,
    input  pfc_pkg::t_in_item              i_item,
    input  logic [pfc_pkg::CollBits-1:0]   i_latches,
    output pfc_pkg::t_out_item             o_item,
    output logic [pfc_pkg::CollBits-1:0]   o_hits
);
    import pfc_pkg::*;

    logic [PatternBits-1:0] pat;
    logic [CellBits-1:0]    slot;
    logic [CellBits-1:0]    cell_right;
    logic [PatIdxBits-1:0]  idx;
    logic                   pf;
    logic                   left;
    logic [7:0]             pf_colour;
    logic [7:0]             colour;
    t_source                src;
    logic p0, p1, m0, m1, bl;

    assign pat        = draw_order(i_cfg);
    assign slot       = i_item.column[7:2];
    assign cell_right = slot - CellBits'(PatternBits);
    assign left       = i_item.column < 8'(HalfColumns);

    always_comb begin
        idx = '0;
        pf  = 1'b0;
        if (slot < CellBits'(PatternBits)) begin
            idx = slot[PatIdxBits-1:0];
            pf  = pat[idx];
        end else if (slot < CellBits'(2 * PatternBits)) begin
            // right half: mirrored when reflect is set
            idx = i_cfg.reflect
                ? PatIdxBits'(PatternBits - 1) - cell_right[PatIdxBits-1:0]
                : cell_right[PatIdxBits-1:0];
            pf  = pat[idx];
        end
    end

    assign p0 = i_item.has_player0;
    assign p1 = i_item.has_player1;
    assign m0 = i_item.has_missile0;
    assign m1 = i_item.has_missile1;
    assign bl = i_item.has_ball;

    assign o_hits = {m0 & m1, p0 & p1, bl & pf, m1 & bl, m1 & pf, m0 & bl, m0 & pf,
                     p1 & bl, p1 & pf, p0 & bl, p0 & pf, m1 & p1, m1 & p0,
                     m0 & p0, m0 & p1};

    assign pf_colour = i_cfg.score_mode
                     ? (left ? i_cfg.player0_colour : i_cfg.player1_colour)
                     : i_cfg.field_colour;

    always_comb begin
        if (p0) begin
            src = SRC_P0;   colour = i_cfg.player0_colour;
        end else if (p1) begin
            src = SRC_P1;   colour = i_cfg.player1_colour;
        end else if (bl) begin
            src = SRC_BALL; colour = pf_colour;
        end else if (m0) begin
            src = SRC_M0;   colour = i_cfg.player0_colour;
        end else if (m1) begin
            src = SRC_M1;   colour = i_cfg.player1_colour;
        end else if (pf) begin
            src = SRC_PF;   colour = pf_colour;
        end else begin
            src = SRC_BG;   colour = i_cfg.backdrop_colour;
        end
    end

    assign o_item.hue             = colour[7:4];
    assign o_item.luminance       = colour[3:1];
    assign o_item.source          = src;
    assign o_item.field_bit       = pf;
    assign o_item.collision_flags = i_latches | o_hits;

endmodule

>>> design/playfield_pixel_compositor.sv
// Top level of the playfield pixel compositor.
// Path from input transaction to result transaction: input register, then result register.
// Throughput: one pixel per cycle while the output is not stalled; the pixel logic sits between the two registers.
// While the result register waits on stall, an empty input register still takes one pixel.
// Synchronous active-low reset clears valids, config registers and collision latches.
module playfield_pixel_compositor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  pfc_pkg::t_in_item                 i_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output pfc_pkg::t_out_item                o_item,
    input  logic                              i_cfg_we,
    input  logic [pfc_pkg::CfgIndexBits-1:0]  i_cfg_index,
    input  logic [pfc_pkg::CfgDataBits-1:0]   i_cfg_data
);
    import pfc_pkg::*;

    t_cfg                cfg;
    logic                r_in_valid;
    t_in_item            r_in_item;
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic [CollBits-1:0] r_latches;
    t_out_item           n_out_item;
    logic [CollBits-1:0] hits;
    logic                out_free;
    logic                advance;

    pfc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pfc_compose u_compose (
        .i_cfg    (cfg),
        .i_item   (r_in_item),
        .i_latches(r_latches),
        .o_item   (n_out_item),
        .o_hits   (hits)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_latches   <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_latches <= r_latches | hits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_item <= i_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

>>> design/pfc_checker.sv
// Port-level checker for the playfield pixel compositor, bound to the top level.
`include "assert_macros.svh"

module pfc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input pfc_pkg::t_in_item   i_item,
    input logic                o_valid,
    input logic                i_stall,
    input pfc_pkg::t_out_item  o_item
);
    import pfc_pkg::*;

    logic [CollBits-1:0] r_last_flags;

    // flags of the last delivered transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_flags <= '0;
        end else if (o_valid && !i_stall) begin
            r_last_flags <= o_item.collision_flags;
        end
    end

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_item))
    `ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid)
    `ASSERT_IMPLY(a_flags_sticky, i_clk, i_rst_n, o_valid && !i_stall,
                  (o_item.collision_flags & r_last_flags) == r_last_flags)
    `ASSERT_IMPLY(a_source_field, i_clk, i_rst_n, o_valid,
                  (o_item.source != SRC_BG || !o_item.field_bit) &&
                  (o_item.source != SRC_PF || o_item.field_bit))
    `ASSERT_IMPLY(a_source_code, i_clk, i_rst_n, o_valid, o_item.source <= SRC_BG)

endmodule

bind playfield_pixel_compositor pfc_checker u_pfc_checker (.*);
